// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the frame deframer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/wsd_pkg.sv =====
// ----------------------------------------------------------------------------
// wsd_pkg
// Types and codes shared by the frame deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package wsd_pkg;

   // Parser phase codes
   typedef enum logic [2:0] {
      PH_HDR0    = 3'd0,
      PH_HDR1    = 3'd1,
      PH_EXT     = 3'd2,
      PH_MASK    = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_RAW     = 3'd5,
      PH_DROP    = 3'd6
   } phase_type;

   // Result kinds
   localparam logic [2:0] KIND_PAYLOAD  = 3'd0;
   localparam logic [2:0] KIND_PONG     = 3'd1;
   localparam logic [2:0] KIND_INVALID  = 3'd2;
   localparam logic [2:0] KIND_RAW      = 3'd3;
   localparam logic [2:0] KIND_UNMASKED = 3'd4;

   // Opcodes and length codes
   localparam logic [3:0] OP_CONTINUATION = 4'h0;
   localparam logic [3:0] OP_PING         = 4'h9;
   localparam logic [6:0] LEN_EXT16       = 7'd126;
   localparam logic [6:0] LEN_EXT64       = 7'd127;

   // Remaining header byte counts after the length byte, less one
   localparam logic [2:0] CNT_EXT16 = 3'd1;
   localparam logic [2:0] CNT_EXT64 = 3'd7;
   localparam logic [2:0] CNT_MASK  = 3'd3;

   // One result item from the parser
   typedef struct packed {
      logic       valid;
      logic [2:0] kind;
      logic [7:0] data;
      logic [3:0] opcode;
      logic       fin;
      logic       last;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/wsd_parser.sv =====
// ----------------------------------------------------------------------------
// wsd_parser
// Frame header/mask/payload state machine; one byte per step, result is
// combinational from the current state and byte.
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_parser (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step,
   input  wire logic [7:0]         rx_byte,
   input  wire logic               end_of_buffer,
   output wsd_pkg::result_type     result
);
   import wsd_pkg::*;
`include "assert_macros.svh"

   phase_type   phase_ff, phase_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic        fin_ff, fin_in;
   logic [31:0] length_ff, length_in;
   logic [2:0]  count_ff, count_in;
   logic [31:0] key_ff, key_in;
   logic [31:0] index_ff, index_in;

   logic [3:0]  hdr_op;
   logic        hdr_reserved;
   logic        pay_last;
   logic [7:0]  key_byte;

   // Decode helpers
   assign hdr_op   = rx_byte[3:0];
   assign pay_last = (index_ff == (length_ff - 32'd1));

   always_comb begin
      hdr_reserved = (hdr_op inside {[4'h4:4'h7], [4'hC:4'hF]});
   end

   // Mask key byte, most significant first
   always_comb begin
      case (index_ff[1:0])
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   // Next state
   always_comb begin
      phase_in  = phase_ff;
      opcode_in = opcode_ff;
      fin_in    = fin_ff;
      length_in = length_ff;
      count_in  = count_ff;
      key_in    = key_ff;
      index_in  = index_ff;
      case (phase_ff)
         PH_HDR1: begin
            if (!rx_byte[7]) begin
               phase_in = end_of_buffer ? PH_HDR0 : PH_DROP;
            end else if (rx_byte[6:0] == LEN_EXT16) begin
               length_in = '0;
               count_in  = CNT_EXT16;
               phase_in  = PH_EXT;
            end else if (rx_byte[6:0] == LEN_EXT64) begin
               length_in = '0;
               count_in  = CNT_EXT64;
               phase_in  = PH_EXT;
            end else begin
               length_in = {25'd0, rx_byte[6:0]};
               count_in  = CNT_MASK;
               phase_in  = PH_MASK;
            end
         end
         PH_EXT: begin
            length_in = {length_ff[23:0], rx_byte};
            if (count_ff == 3'd0) begin
               count_in = CNT_MASK;
               phase_in = PH_MASK;
            end else begin
               count_in = count_ff - 3'd1;
            end
         end
         PH_MASK: begin
            key_in = {key_ff[23:0], rx_byte};
            if (count_ff == 3'd0) begin
               index_in = '0;
               if (length_ff == 32'd0) begin
                  phase_in = end_of_buffer ? PH_HDR0 : PH_DROP;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end else begin
               count_in = count_ff - 3'd1;
            end
         end
         PH_PAYLOAD: begin
            if (pay_last) begin
               phase_in = PH_HDR0;
            end else begin
               index_in = index_ff + 32'd1;
            end
         end
         PH_RAW, PH_DROP: begin
            if (end_of_buffer) begin
               phase_in = PH_HDR0;
            end
         end
         default: begin
            opcode_in = hdr_op;
            fin_in    = rx_byte[7];
            if (hdr_reserved) begin
               phase_in = end_of_buffer ? PH_HDR0 : PH_RAW;
            end else if (hdr_op == OP_CONTINUATION || hdr_op == OP_PING) begin
               phase_in = end_of_buffer ? PH_HDR0 : PH_DROP;
            end else begin
               phase_in = PH_HDR1;
            end
         end
      endcase
   end

   // Result item
   always_comb begin
      result        = '0;
      result.kind   = KIND_PAYLOAD;
      result.opcode = opcode_ff;
      result.fin    = fin_ff;
      case (phase_ff)
         PH_HDR1: begin
            if (!rx_byte[7]) begin
               result.valid = 1'b1;
               result.kind  = KIND_UNMASKED;
            end
         end
         PH_PAYLOAD: begin
            if (length_ff > 32'd1) begin
               result.valid = 1'b1;
               result.data  = rx_byte ^ key_byte;
               result.last  = pay_last;
            end
         end
         PH_RAW: begin
            result.valid = 1'b1;
            result.kind  = KIND_RAW;
            result.data  = rx_byte;
            result.last  = end_of_buffer;
         end
         PH_EXT, PH_MASK, PH_DROP: begin
            result.valid = 1'b0;
         end
         default: begin
            result.opcode = hdr_op;
            result.fin    = rx_byte[7];
            if (hdr_reserved) begin
               result.valid = 1'b1;
               result.kind  = KIND_INVALID;
            end else if (hdr_op == OP_PING) begin
               result.valid = 1'b1;
               result.kind  = KIND_PONG;
            end
         end
      endcase
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HDR0;
         opcode_ff <= '0;
         fin_ff    <= 1'b0;
         length_ff <= '0;
         count_ff  <= '0;
         key_ff    <= '0;
         index_ff  <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         opcode_ff <= opcode_in;
         fin_ff    <= fin_in;
         length_ff <= length_in;
         count_ff  <= count_in;
         key_ff    <= key_in;
         index_ff  <= index_in;
      end
   end

   // Raw pass-through lasts until the buffer end
   `ASSERT_NEXT(a_raw_holds, clock, reset,
      step && phase_ff == PH_RAW && !end_of_buffer, phase_ff == PH_RAW,
      "raw mode left before buffer end")

   // Final payload byte returns to header parsing
   `ASSERT_NEXT(a_payload_done, clock, reset,
      step && phase_ff == PH_PAYLOAD && pay_last, phase_ff == PH_HDR0,
      "payload end did not return to header")

endmodule

`default_nettype wire

// ===== rtl/websocket_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Receive-side frame deframer: header decode, mask unmasking, raw and drop
// handling, one byte per cycle while neither channel stalls.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake          payload
//  req      in   req_valid/stall    rx_byte, end_of_buffer
//  rsp      out  rsp_valid/stall    result_kind, data_byte, frame_opcode,
//                                   final_fragment, last_byte
//
//  One item per cycle sustained while rsp_stall is low; a byte's result reaches
//  the rsp port by way of the input register, then the parser into the result
//  register.
//  Reset clears the parser to header byte zero and empties both registers.
//  rsp_stall holds the result register; the input register still takes one
//  more item, after which req_stall rises until the result moves on.
//
`default_nettype none

module websocket_frame_deframer (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_rx_byte,
   input  wire logic       req_end_of_buffer,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [2:0]      rsp_result_kind,
   output logic [7:0]      rsp_data_byte,
   output logic [3:0]      rsp_frame_opcode,
   output logic            rsp_final_fragment,
   output logic            rsp_last_byte
);
   import wsd_pkg::*;
`include "assert_macros.svh"

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_eob_ff;
   logic       rsp_valid_ff;
   result_type rsp_ff;
   result_type result;
   logic       out_free;
   logic       fire;
   logic       accept;

   // Handshake control
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_rx_byte;
         in_eob_ff  <= req_end_of_buffer;
      end
   end

   // Parser
   wsd_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .step          (fire),
      .rx_byte       (in_byte_ff),
      .end_of_buffer (in_eob_ff),
      .result        (result)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= fire && result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && out_free) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_kind    = rsp_ff.kind;
   assign rsp_data_byte      = rsp_ff.data;
   assign rsp_frame_opcode   = rsp_ff.opcode;
   assign rsp_final_fragment = rsp_ff.fin;
   assign rsp_last_byte      = rsp_ff.last;

   // A blocked item in the input register is kept
   `ASSERT_NEXT(a_in_kept, clock, reset,
      in_valid_ff && !out_free, in_valid_ff,
      "queued item lost while output blocked")

   // Reset empties the result register
   `ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid,
      "result valid right after reset")

endmodule

`default_nettype wire

// ===== sim/deframe_scoreboard.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deframe_scoreboard
// Watches both channels of the frame deframer. Every byte taken on the req
// side runs through a behavioral copy of the header/mask/payload parser; the
// results it predicts are queued and matched in order against the rsp side.
// ----------------------------------------------------------------------------
module deframe_scoreboard (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_rx_byte,
   input  logic       req_end_of_buffer,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [2:0] rsp_result_kind,
   input  logic [7:0] rsp_data_byte,
   input  logic [3:0] rsp_frame_opcode,
   input  logic       rsp_final_fragment,
   input  logic       rsp_last_byte,
   output int         fail_count,
   output int         pending
);
   import wsd_pkg::*;

   // Opcode range bounds: data ops above 3 and control ops above B are reserved
   localparam logic [3:0] OP_DATA_TOP  = 4'h3;
   localparam logic [3:0] OP_CTRL_BASE = 4'h8;
   localparam logic [3:0] OP_CTRL_TOP  = 4'hB;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] data;
      logic [3:0] opcode;
      logic       fin;
      logic       last;
   } deframe_result_type;

   deframe_result_type expected_results[$];

   // Parser state
   phase_type   phase;
   logic [3:0]  frame_op;
   logic        frame_fin;
   logic [31:0] frame_len;
   logic [2:0]  hdr_left;
   logic [31:0] mask_word;
   logic [31:0] byte_idx;

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   task automatic queue_result(input logic [2:0] kind, input logic [7:0] data,
                               input logic last);
      deframe_result_type r;
      r.kind   = kind;
      r.data   = data;
      r.opcode = frame_op;
      r.fin    = frame_fin;
      r.last   = last;
      expected_results.push_back(r);
   endtask

   // One byte through the parser
   task automatic deframe_byte(input logic [7:0] b, input logic eob);
      logic [1:0] lane;
      logic [7:0] key_byte;
      logic       is_last;
      logic [3:0] op;
      case (phase)
         PH_HDR1: begin
            if (!b[7]) begin
               queue_result(KIND_UNMASKED, 8'h00, 1'b0);
               phase = eob ? PH_HDR0 : PH_DROP;
            end else if (b[6:0] == LEN_EXT16) begin
               frame_len = '0;
               hdr_left  = CNT_EXT16;
               phase     = PH_EXT;
            end else if (b[6:0] == LEN_EXT64) begin
               frame_len = '0;
               hdr_left  = CNT_EXT64;
               phase     = PH_EXT;
            end else begin
               frame_len = {25'd0, b[6:0]};
               hdr_left  = CNT_MASK;
               phase     = PH_MASK;
            end
         end
         PH_EXT: begin
            // only the low 32 bits of a long length survive
            frame_len = {frame_len[23:0], b};
            if (hdr_left == 3'd0) begin
               hdr_left = CNT_MASK;
               phase    = PH_MASK;
            end else
               hdr_left = hdr_left - 3'd1;
         end
         PH_MASK: begin
            mask_word = {mask_word[23:0], b};
            if (hdr_left == 3'd0) begin
               byte_idx = '0;
               if (frame_len == '0)
                  phase = eob ? PH_HDR0 : PH_DROP;
               else
                  phase = PH_PAYLOAD;
            end else
               hdr_left = hdr_left - 3'd1;
         end
         PH_PAYLOAD: begin
            lane     = 2'd3 - byte_idx[1:0];
            key_byte = mask_word[{lane, 3'b000} +: 8];
            is_last  = (byte_idx == frame_len - 32'd1);
            // a one-byte frame is swallowed silently
            if (frame_len > 32'd1)
               queue_result(KIND_PAYLOAD, b ^ key_byte, is_last);
            if (is_last)
               phase = PH_HDR0;
            else
               byte_idx = byte_idx + 32'd1;
         end
         PH_RAW: begin
            queue_result(KIND_RAW, b, eob);
            if (eob)
               phase = PH_HDR0;
         end
         PH_DROP: begin
            if (eob)
               phase = PH_HDR0;
         end
         default: begin
            op        = b[3:0];
            frame_op  = op;
            frame_fin = b[7];
            if ((op > OP_DATA_TOP && op < OP_CTRL_BASE) || op > OP_CTRL_TOP) begin
               queue_result(KIND_INVALID, 8'h00, 1'b0);
               phase = eob ? PH_HDR0 : PH_RAW;
            end else if (op == OP_CONTINUATION) begin
               phase = eob ? PH_HDR0 : PH_DROP;
            end else if (op == OP_PING) begin
               queue_result(KIND_PONG, 8'h00, 1'b0);
               phase = eob ? PH_HDR0 : PH_DROP;
            end else
               phase = PH_HDR1;
         end
      endcase
   endtask

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count = fail_count + 1;
      end
   endtask

   always @(posedge clock) begin : track
      deframe_result_type want;
      if (reset) begin
         phase     = PH_HDR0;
         frame_op  = '0;
         frame_fin = 1'b0;
         frame_len = '0;
         hdr_left  = '0;
         mask_word = '0;
         byte_idx  = '0;
         expected_results.delete();
         pending <= 0;
      end else begin
         if (req_valid && !req_stall)
            deframe_byte(req_rx_byte, req_end_of_buffer);

         // match each delivered result against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result: kind %0d data %0h", rsp_result_kind,
                      rsp_data_byte);
               fail_count = fail_count + 1;
            end else begin
               want = expected_results.pop_front();
               check_field("result_kind", 8'(want.kind), 8'(rsp_result_kind));
               check_field("data_byte", want.data, rsp_data_byte);
               check_field("frame_opcode", 8'(want.opcode), 8'(rsp_frame_opcode));
               check_field("final_fragment", 8'(want.fin), 8'(rsp_final_fragment));
               check_field("last_byte", 8'(want.last), 8'(rsp_last_byte));
            end
         end
         pending <= expected_results.size();
      end
   end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Byte stream stimulus for the frame deframer: a handful of hand-built frames
// covering the short-length header paths, then random masked frames mixed
// with ping, continuation, reserved and unmasked headers, with random req gaps
// and random rsp back-pressure. Checking lives in deframe_scoreboard.
// ----------------------------------------------------------------------------
module tb_top;
   import wsd_pkg::*;

   // Opcodes used to build frames
   localparam logic [3:0] OP_TEXT       = 4'h1;
   localparam logic [3:0] OP_BINARY     = 4'h2;
   localparam logic [3:0] OP_DATA_EXTRA = 4'h3;
   localparam logic [3:0] OP_CLOSE      = 4'h8;
   localparam logic [3:0] OP_PONG       = 4'hA;
   localparam logic [3:0] OP_CTRL_EXTRA = 4'hB;
   localparam logic [3:0] OP_RSV_DATA   = 4'h4;
   localparam logic [3:0] OP_RSV_CTRL   = 4'hC;
   localparam logic [3:0] OP_RSV_TOP    = 4'hF;

   // Length encodings
   localparam int FORM_SHORT = 0;
   localparam int FORM_EXT16 = 1;
   localparam int FORM_EXT64 = 2;

   // Header-only sequences
   localparam int SEQ_PING     = 0;
   localparam int SEQ_CONT     = 1;
   localparam int SEQ_RESERVED = 2;
   localparam int SEQ_UNMASKED = 3;

   localparam int RANDOM_TARGET = 450;
   localparam int PAUSE_POINT   = 240;
   localparam int DRAIN_CYCLES  = 16;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte = 8'h00;
   logic       req_end_of_buffer = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [2:0] rsp_result_kind;
   logic [7:0] rsp_data_byte;
   logic [3:0] rsp_frame_opcode;
   logic       rsp_final_fragment;
   logic       rsp_last_byte;
   int         fail_count;
   int         pending;

   bit req_calm = 1'b0;
   bit rsp_calm = 1'b0;
   int stall_left = 0;
   int stall_draw;
   int counted_bytes = 0;

   always #1 clock = ~clock;

   websocket_frame_deframer DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .req_end_of_buffer (req_end_of_buffer),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_frame_opcode  (rsp_frame_opcode),
      .rsp_final_fragment(rsp_final_fragment),
      .rsp_last_byte     (rsp_last_byte)
   );

   deframe_scoreboard scoreboard (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .req_end_of_buffer (req_end_of_buffer),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_frame_opcode  (rsp_frame_opcode),
      .rsp_final_fragment(rsp_final_fragment),
      .rsp_last_byte     (rsp_last_byte),
      .fail_count        (fail_count),
      .pending           (pending)
   );

   // Result side back-pressure: after each item, stall for a random while
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (rsp_stall) begin
         if (stall_left <= 1)
            rsp_stall <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (rsp_valid) begin
         if ($urandom_range(0, 31) == 0)
            rsp_calm = !rsp_calm;
         stall_draw = rsp_calm ? 0 : $urandom_range(0, 11);
         if (stall_draw > 0) begin
            rsp_stall  <= 1'b1;
            stall_left <= stall_draw;
         end
      end
   end

   // Offer one byte after a random gap and hold it until taken
   task automatic send_byte(input logic [7:0] value, input logic eob);
      int gap;
      if ($urandom_range(0, 31) == 0)
         req_calm = !req_calm;
      gap = req_calm ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_rx_byte       <= value;
      req_end_of_buffer <= eob;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      counted_bytes += 1;
   endtask

   function automatic logic [3:0] pick_frame_op();
      case ($urandom_range(0, 5))
         0:       return OP_TEXT;
         1:       return OP_BINARY;
         2:       return OP_DATA_EXTRA;
         3:       return OP_CLOSE;
         4:       return OP_PONG;
         default: return OP_CTRL_EXTRA;
      endcase
   endfunction

   // Masked frame: header, length, key, random payload. With rand_eob the
   // buffer may end anywhere inside the frame.
   task automatic send_masked_frame(input logic fin, input logic [3:0] op,
                                    input logic [31:0] len, input int form,
                                    input logic [31:0] key, input logic rand_eob);
      logic [7:0]  bytes_q[$];
      logic [31:0] high_word;
      logic        tail_eob;
      bytes_q.push_back({fin, 3'($urandom), op});
      case (form)
         FORM_EXT16: begin
            bytes_q.push_back({1'b1, LEN_EXT16});
            bytes_q.push_back(len[15:8]);
            bytes_q.push_back(len[7:0]);
         end
         FORM_EXT64: begin
            // upper word is dropped by the parser, so it can be anything
            high_word = $urandom;
            bytes_q.push_back({1'b1, LEN_EXT64});
            for (int i = 3; i >= 0; i--)
               bytes_q.push_back(high_word[8*i +: 8]);
            for (int i = 3; i >= 0; i--)
               bytes_q.push_back(len[8*i +: 8]);
         end
         default: bytes_q.push_back({1'b1, len[6:0]});
      endcase
      for (int i = 3; i >= 0; i--)
         bytes_q.push_back(key[8*i +: 8]);
      for (int i = 0; i < len; i++)
         bytes_q.push_back(8'($urandom));
      // an empty frame without buffer end would swallow what follows
      tail_eob = (len == 0 || !rand_eob) ? 1'b1 : 1'($urandom);
      foreach (bytes_q[i])
         send_byte(bytes_q[i], (i == bytes_q.size() - 1) ? tail_eob :
                   (rand_eob && $urandom_range(0, 15) == 0));
   endtask

   // Header that ends the frame early, then trailing bytes up to buffer end
   task automatic send_control(input int seq);
      logic [3:0] op;
      int         trail;
      trail = $urandom_range(0, 6);
      case (seq)
         SEQ_PING:
            send_byte({1'($urandom), 3'($urandom), OP_PING}, trail == 0);
         SEQ_CONT:
            send_byte({1'($urandom), 3'($urandom), OP_CONTINUATION}, trail == 0);
         SEQ_RESERVED: begin
            op = 4'($urandom_range(0, 7));
            op = (op < 4'd4) ? OP_RSV_DATA + op : OP_RSV_CTRL + op - 4'd4;
            send_byte({1'($urandom), 3'($urandom), op}, trail == 0);
         end
         default: begin
            send_byte({1'($urandom), 3'($urandom), pick_frame_op()}, 1'b0);
            send_byte({1'b0, 7'($urandom)}, trail == 0);
         end
      endcase
      for (int i = 1; i <= trail; i++)
         send_byte(8'($urandom), i == trail);
   endtask

   initial begin
      int          sel;
      int          form;
      logic [31:0] len;
      bit          paused;
      paused = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: ping, continuation, reserved, unmasked and short masked headers
      send_byte({1'b1, 3'b000, OP_PING}, 1'b1);
      send_byte({1'b0, 3'b111, OP_CONTINUATION}, 1'b1);
      send_byte({1'b1, 3'b000, OP_RSV_DATA}, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte({1'b0, 3'b000, OP_RSV_TOP}, 1'b1);
      send_byte({1'b1, 3'b000, OP_TEXT}, 1'b0);
      send_byte({1'b0, 7'h7F}, 1'b1);
      send_masked_frame(1'b1, OP_CLOSE, 32'd0, FORM_SHORT, 32'hFFFF_FFFF, 1'b0);
      send_masked_frame(1'b0, OP_BINARY, 32'd1, FORM_SHORT, 32'h0000_0000, 1'b0);
      send_masked_frame(1'b1, OP_PONG, 32'd2, FORM_SHORT, 32'hA5C3_3C5A, 1'b0);

      // Random: mostly well-formed masked frames
      while (counted_bytes < RANDOM_TARGET) begin
         // once, let everything in flight drain before going on
         if (!paused && counted_bytes >= PAUSE_POINT) begin
            paused = 1'b1;
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending != 0) @(posedge clock);
         end
         sel = $urandom_range(0, 9);
         case (sel)
            6: send_control(SEQ_PING);
            7: send_control(SEQ_CONT);
            8: send_control(SEQ_RESERVED);
            9: send_control(SEQ_UNMASKED);
            default: begin
               sel = $urandom_range(0, 19);
               if (sel < 12) begin
                  form = FORM_SHORT;
                  len  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 125) :
                                                       $urandom_range(0, 12);
               end else if (sel < 17) begin
                  form = FORM_EXT16;
                  len  = ($urandom_range(0, 7) == 0) ? $urandom_range(126, 300) :
                                                       $urandom_range(0, 40);
               end else begin
                  form = FORM_EXT64;
                  len  = $urandom_range(0, 20);
               end
               send_masked_frame(1'($urandom), pick_frame_op(), len, form, $urandom,
                                 1'b1);
            end
         endcase
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // Watchdog
   initial begin
      #1_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
